/* sv/sync_length_crc8_deframer_top_defines.svh */
// Assertion helpers shared by the deframer modules.
// Each expects clk and rst to be visible in the module that uses it.
`ifndef SYNC_LENGTH_CRC8_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_CRC8_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define SLDF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sldf: check failed");

// Next-cycle implication, off during reset
`define SLDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sldf: check failed");

`endif

/* sv/sldf_pkg.sv */
package sldf_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST   = 8'd170;
  localparam logic [BYTE_W-1:0] CRC_POLY_RST    = 8'd7;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1024;

  // Default depth of the command queue
  localparam int SLDF_QUEUE_DEPTH = 4;

  // Command kinds passed from the parser to the executor
  localparam logic [1:0] CMD_CRC_INIT = 2'd0;  // type byte, CRC restarts
  localparam logic [1:0] CMD_CRC_UPD  = 2'd1;  // length byte, CRC only
  localparam logic [1:0] CMD_PAYLOAD  = 2'd2;  // payload byte, CRC and result
  localparam logic [1:0] CMD_END      = 2'd3;  // CRC byte, compare and result

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  index;
    logic [BYTE_W-1:0] mtype;
    logic [LEN_W-1:0]  length;
  } sldf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sldf_q_status_t;

  // One byte of CRC-8, MSB first, no reflection
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b,
                                                  input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      v = v[BYTE_W-1] ? ((v << 1) ^ poly) : (v << 1);
    end
    return v;
  endfunction

endpackage

/* sv/sldf_if.sv */
// Received byte channel
interface sldf_byte_if import sldf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

// Result channel
interface sldf_result_if import sldf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [LEN_W-1:0]  payload_index;
  logic [BYTE_W-1:0] message_type;
  logic [LEN_W-1:0]  frame_length;
  logic              frame_end;
  logic              crc_match;

  modport source (output valid, output payload_byte, output payload_index,
                  output message_type, output frame_length, output frame_end,
                  output crc_match, input ready);
  modport sink   (input valid, input payload_byte, input payload_index,
                  input message_type, input frame_length, input frame_end,
                  input crc_match, output ready);
endinterface

// Register write channel
interface sldf_cfg_if import sldf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sldf_front.sv */
`include "sync_length_crc8_deframer_top_defines.svh"

// Frame parser: tracks the header, classifies each byte into a command.
module sldf_front import sldf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sldf_byte_if.sink         rx,
  input  logic [BYTE_W-1:0] sync_byte,
  input  logic [LEN_W-1:0]  max_payload_length,
  input  sldf_q_status_t    q_status,
  output logic              push,
  output sldf_cmd_t         push_cmd
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] held_type, held_type_next;
  logic [LEN_W-1:0]  held_length, held_length_next;
  logic [LEN_W-1:0]  byte_counter, byte_counter_next;
  logic [LEN_W-1:0]  len_full;
  logic [LEN_W-1:0]  counter_inc;
  logic              accept;
  logic              cmd_en;

  assign rx.ready    = !q_status.full;
  assign accept      = rx.valid && rx.ready;
  assign len_full    = {rx.rx_data, held_length[BYTE_W-1:0]};
  assign counter_inc = byte_counter + 1'b1;

  // Phase decode and command build
  always_comb begin
    phase_next        = phase;
    held_type_next    = held_type;
    held_length_next  = held_length;
    byte_counter_next = byte_counter;
    cmd_en            = 1'b0;
    push_cmd.kind     = CMD_CRC_UPD;
    push_cmd.data     = rx.rx_data;
    push_cmd.index    = '0;
    push_cmd.mtype    = held_type;
    push_cmd.length   = held_length;
    case (phase)
      PH_HUNT: begin
        if (rx.rx_data == sync_byte) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        held_type_next = rx.rx_data;
        cmd_en         = 1'b1;
        push_cmd.kind  = CMD_CRC_INIT;
        phase_next     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_length_next = {{(LEN_W-BYTE_W){1'b0}}, rx.rx_data};
        cmd_en           = 1'b1;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length_next = len_full;
        cmd_en           = 1'b1;
        if (len_full > max_payload_length) begin
          phase_next = PH_HUNT;
        end else begin
          byte_counter_next = '0;
          phase_next        = (len_full != '0) ? PH_PAYLOAD : PH_CRC;
        end
      end
      PH_PAYLOAD: begin
        cmd_en            = 1'b1;
        push_cmd.kind     = CMD_PAYLOAD;
        push_cmd.index    = byte_counter;
        byte_counter_next = counter_inc;
        if (counter_inc >= held_length) phase_next = PH_CRC;
      end
      PH_CRC: begin
        cmd_en        = 1'b1;
        push_cmd.kind = CMD_END;
        phase_next    = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign push = accept && cmd_en;

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      held_type    <= '0;
      held_length  <= '0;
      byte_counter <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      held_type    <= held_type_next;
      held_length  <= held_length_next;
      byte_counter <= byte_counter_next;
    end
  end

  `SLDF_ASSERT_IMPLIES(a_payload_in_range, phase == PH_PAYLOAD, byte_counter < held_length)
  `SLDF_ASSERT_IMPLIES(a_no_push_when_full, q_status.full, !push)
  `SLDF_ASSERT_NEXT(a_hunt_after_end, accept && phase == PH_CRC, phase == PH_HUNT)

endmodule

/* sv/sldf_queue.sv */
`include "sync_length_crc8_deframer_top_defines.svh"

// Short command queue between parser and executor.
module sldf_queue import sldf_pkg::*; #(
  parameter int DEPTH = SLDF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sldf_cmd_t      push_cmd,
  input  logic           pop,
  output sldf_cmd_t      head,
  output sldf_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

  sldf_cmd_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == FULLC);
  assign status.empty = (count == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SLDF_ASSERT_IMPLIES(a_count_bound, 1'b1, count <= FULLC)
  `SLDF_ASSERT_IMPLIES(a_pop_nonempty, pop, count != '0)
  `SLDF_ASSERT_IMPLIES(a_push_not_full, push, count != FULLC)

endmodule

/* sv/sldf_back.sv */
`include "sync_length_crc8_deframer_top_defines.svh"

// Executor: runs the CRC over queued commands and registers the results.
module sldf_back import sldf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] crc_polynomial,
  input  sldf_cmd_t         head,
  input  sldf_q_status_t    q_status,
  output logic              pop,
  sldf_result_if.source     res
);

  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] crc_base;
  logic [BYTE_W-1:0] crc_new;
  logic              emits;
  logic              slot_free;
  logic              out_valid;

  assign emits     = (head.kind == CMD_PAYLOAD) || (head.kind == CMD_END);
  assign slot_free = !out_valid || res.ready;
  assign pop       = !q_status.empty && (!emits || slot_free);
  assign crc_base  = (head.kind == CMD_CRC_INIT) ? '0 : running_crc;
  assign crc_new   = crc8_step(crc_base, head.data, crc_polynomial);
  assign res.valid = out_valid;

  // Running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (pop && head.kind != CMD_END) begin
      running_crc <= crc_new;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emits) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      res.message_type <= head.mtype;
      res.frame_length <= head.length;
      if (head.kind == CMD_END) begin
        res.payload_byte  <= '0;
        res.payload_index <= '0;
        res.frame_end     <= 1'b1;
        res.crc_match     <= (head.data == running_crc);
      end else begin
        res.payload_byte  <= head.data;
        res.payload_index <= head.index;
        res.frame_end     <= 1'b0;
        res.crc_match     <= 1'b0;
      end
    end
  end

  `SLDF_ASSERT_IMPLIES(a_end_word_clean, out_valid && res.frame_end,
                       res.payload_byte == '0 && res.payload_index == '0)
  `SLDF_ASSERT_IMPLIES(a_no_overwrite, out_valid && !res.ready, !(pop && emits))
  `SLDF_ASSERT_NEXT(a_word_held, out_valid && !res.ready, out_valid)

endmodule

/* sv/sync_length_crc8_deframer_top.sv */
// Length-prefixed frame deframer with CRC-8 check. Bytes on rx are parsed as
// sync, type, 16-bit little-endian length, payload and one CRC byte; every
// payload byte comes out on res with its index, and after the CRC byte one end
// word carries type, length and the match flag. A length above
// max_payload_length drops the frame silently. Throughput is one byte per
// clock: the parser takes a byte each cycle while the command queue
// (QUEUE_DEPTH entries) has room, and the executor retires one command per
// cycle while the queue is not empty and res can take the word of a payload
// or end command. A result word passes a queue slot and the output register.
// Registers (0 sync byte, 1 polynomial, 2 max length) are written through cfg,
// which is always ready; write them only while no frame is in flight.
module sync_length_crc8_deframer_top import sldf_pkg::*; #(
  parameter int QUEUE_DEPTH = SLDF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  sldf_byte_if.sink     rx,
  sldf_result_if.source res,
  sldf_cfg_if.sink      cfg
);

  logic [BYTE_W-1:0] sync_byte;
  logic [BYTE_W-1:0] crc_polynomial;
  logic [LEN_W-1:0]  max_payload_length;
  logic              push;
  logic              pop;
  sldf_cmd_t         push_cmd;
  sldf_cmd_t         head;
  sldf_q_status_t    q_status;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte          <= SYNC_BYTE_RST;
      crc_polynomial     <= CRC_POLY_RST;
      max_payload_length <= MAX_PAYLOAD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SYNC_BYTE:   sync_byte          <= cfg.data[BYTE_W-1:0];
        CFG_CRC_POLY:    crc_polynomial     <= cfg.data[BYTE_W-1:0];
        CFG_MAX_PAYLOAD: max_payload_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sldf_front u_front (
    .clk                (clk),
    .rst                (rst),
    .rx                 (rx),
    .sync_byte          (sync_byte),
    .max_payload_length (max_payload_length),
    .q_status           (q_status),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  sldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sldf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .crc_polynomial (crc_polynomial),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .res            (res)
  );

endmodule
